FILE: rtl/tlpm_pkg.sv
// Shared types, constants and channel payloads for the command line prefix matcher.
package tlpm_pkg;

   localparam int MAX_ENTRIES    = 16;
   localparam int MAX_PREFIX_LEN = 8;

   localparam int ENTRY_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int POS_W   = $clog2(MAX_PREFIX_LEN + 1);
   localparam int BIDX_W  = (MAX_PREFIX_LEN > 1) ? $clog2(MAX_PREFIX_LEN) : 1;

   localparam logic [1:0] CMD_BYTE   = 2'd0;
   localparam logic [1:0] CMD_PREFIX = 2'd1;
   localparam logic [1:0] CMD_CLEAR  = 2'd2;

   localparam logic [1:0] ST_MATCH   = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;

   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TILDE  = 8'h7E;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_Z   = 8'h5A;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_Z  = 8'h7A;
   localparam logic [7:0] CASE_DIFF = 8'h20;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
      logic       prefix_last;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  entry_index;
      logic [3:0]  match_length;
      logic [31:0] total_count;
      logic [31:0] invalid_count;
      logic [31:0] unknown_count;
   } rsp_type;

   typedef struct packed {
      logic               feed;
      logic [POS_W-1:0]   pos;
      logic [7:0]         chr;
      logic               line_clear;
      logic               clean_zero;
      logic               load_sel;
      logic               load_wr;
      logic               load_last;
      logic [ENTRY_W-1:0] load_entry;
      logic [POS_W-1:0]   load_pos;
      logic [POS_W-1:0]   load_len;
      logic [7:0]         load_data;
   } cell_ctrl_type;

   typedef struct packed {
      logic               found;
      logic [ENTRY_W-1:0] index;
   } chain_type;

endpackage

FILE: rtl/tlpm_cell.sv
// One prefix entry cell: stored prefix, length, match flag and priority chain stage.
module tlpm_cell
   import tlpm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_ctrl_type      ctrl,
   input  logic [ENTRY_W-1:0] cell_index,
   input  chain_type          chain_in,
   output chain_type          chain_out
);

   logic [7:0]       bytes_ff [MAX_PREFIX_LEN];
   logic [POS_W-1:0] len_ff;
   logic [POS_W-1:0] len_in;
   logic             valid_ff;
   logic             valid_in;
   logic             match_ff;
   logic             match_in;

   logic             selected;
   logic [7:0]       cur_byte;
   logic [POS_W-1:0] pos_next;
   logic             hit;
   logic             mismatch;

   assign selected = ctrl.load_sel && (ctrl.load_entry == cell_index);
   assign cur_byte = bytes_ff[ctrl.pos[BIDX_W-1:0]];
   assign pos_next = ctrl.pos + POS_W'(1);
   assign hit      = ctrl.feed && valid_ff && match_ff && (len_ff == pos_next)
                     && (cur_byte == ctrl.chr);
   assign mismatch = ctrl.feed && valid_ff && (ctrl.pos < len_ff) && (cur_byte != ctrl.chr);

   assign chain_out.found = chain_in.found | hit;
   assign chain_out.index = chain_in.found ? chain_in.index : cell_index;

   always_comb begin
      len_in   = len_ff;
      valid_in = valid_ff;
      match_in = match_ff;
      if (ctrl.line_clear) begin
         match_in = 1'b1;
      end else if (selected && ctrl.load_last) begin
         match_in = ctrl.clean_zero;
      end else if (mismatch) begin
         match_in = 1'b0;
      end
      if (selected && ctrl.load_last) begin
         len_in   = ctrl.load_len;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         valid_ff <= 1'b0;
         match_ff <= 1'b1;
      end else begin
         len_ff   <= len_in;
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      if (selected && ctrl.load_wr) begin
         bytes_ff[ctrl.load_pos[BIDX_W-1:0]] <= ctrl.load_data;
      end
   end

endmodule

FILE: rtl/tlpm_line.sv
// Line cleaner, registration control, best-match tracking and statistics counters.
module tlpm_line
   import tlpm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  req_type       req,
   input  chain_type     chain,
   output cell_ctrl_type ctrl,
   output logic          res_valid,
   output rsp_type       res
);

   logic               nonempty_ff,  nonempty_in;
   logic               started_ff,   started_in;
   logic               hash_ff,      hash_in;
   logic               pending_ff,   pending_in;
   logic               invalid_ff,   invalid_in;
   logic [POS_W-1:0]   pos_ff,       pos_in;
   logic [ENTRY_W-1:0] best_idx_ff,  best_idx_in;
   logic [POS_W-1:0]   best_len_ff,  best_len_in;
   logic [COUNT_W-1:0] entry_ff,     entry_in;
   logic [POS_W-1:0]   load_pos_ff,  load_pos_in;
   logic [31:0]        total_ff,     total_in;
   logic [31:0]        fmt_ff,       fmt_in;
   logic [31:0]        unk_ff,       unk_in;

   logic             is_byte;
   logic             is_eol;
   logic             is_print;
   logic             is_space;
   logic [7:0]       upper;
   logic             hash_take;
   logic             clean;
   logic             feed;
   logic             finish;
   logic             load_sel;
   logic             load_wr;
   logic [POS_W-1:0] load_next;
   logic [1:0]       status;

   function automatic logic allowed(input logic [7:0] c);
      return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UP_A && c <= CH_UP_Z) ||
             (c >= CH_LOW_A && c <= CH_LOW_Z) || c == CH_COLON || c == CH_UNDER ||
             c == CH_DOT || c == CH_DASH;
   endfunction

   assign is_byte   = accept && (req.command == CMD_BYTE);
   assign is_eol    = is_byte && (req.data_byte == CH_LF || req.data_byte == CH_CR);
   assign is_print  = is_byte && (req.data_byte >= CH_SPACE) && (req.data_byte <= CH_TILDE);
   assign is_space  = req.data_byte == CH_SPACE;
   assign upper     = (req.data_byte >= CH_LOW_A && req.data_byte <= CH_LOW_Z) ?
                      req.data_byte - CASE_DIFF : req.data_byte;
   assign hash_take = hash_ff && (upper == CH_HASH);
   assign clean     = is_print && !is_space && !hash_take;
   assign feed      = clean && (pos_ff < POS_W'(MAX_PREFIX_LEN));
   assign finish    = is_eol && nonempty_ff;

   assign load_sel  = accept && (req.command == CMD_PREFIX) &&
                      (entry_ff < COUNT_W'(MAX_ENTRIES));
   assign load_wr   = load_sel && (load_pos_ff < POS_W'(MAX_PREFIX_LEN));
   assign load_next = load_pos_ff + POS_W'(load_wr);

   assign ctrl.feed       = feed;
   assign ctrl.pos        = pos_ff;
   assign ctrl.chr        = upper;
   assign ctrl.line_clear = finish;
   assign ctrl.clean_zero = pos_ff == '0;
   assign ctrl.load_sel   = load_sel;
   assign ctrl.load_wr    = load_wr;
   assign ctrl.load_last  = req.prefix_last;
   assign ctrl.load_entry = entry_ff[ENTRY_W-1:0];
   assign ctrl.load_pos   = load_pos_ff;
   assign ctrl.load_len   = load_next;
   assign ctrl.load_data  = req.data_byte;

   always_comb begin
      if (invalid_ff || pos_ff == '0) begin
         status = ST_INVALID;
      end else if (best_len_ff == '0) begin
         status = ST_UNKNOWN;
      end else begin
         status = ST_MATCH;
      end
   end

   always_comb begin
      nonempty_in = nonempty_ff;
      started_in  = started_ff;
      hash_in     = hash_ff;
      pending_in  = pending_ff;
      invalid_in  = invalid_ff;
      pos_in      = pos_ff;
      best_idx_in = best_idx_ff;
      best_len_in = best_len_ff;
      entry_in    = entry_ff;
      load_pos_in = load_pos_ff;
      total_in    = total_ff;
      fmt_in      = fmt_ff;
      unk_in      = unk_ff;

      if (finish) begin
         nonempty_in = 1'b0;
         started_in  = 1'b0;
         hash_in     = 1'b1;
         pending_in  = 1'b0;
         invalid_in  = 1'b0;
         pos_in      = '0;
         best_idx_in = '0;
         best_len_in = '0;
      end else if (is_print) begin
         nonempty_in = 1'b1;
         if (is_space) begin
            if (started_ff) begin
               pending_in = 1'b1;
            end
         end else begin
            if (pending_ff) begin
               invalid_in = 1'b1;
               pending_in = 1'b0;
            end
            started_in = 1'b1;
            hash_in    = 1'b0;
            if (!hash_take && !allowed(upper)) begin
               invalid_in = 1'b1;
            end
            if (feed) begin
               pos_in = pos_ff + POS_W'(1);
               if (chain.found) begin
                  best_idx_in = chain.index;
                  best_len_in = pos_ff + POS_W'(1);
               end
            end
         end
      end

      if (load_sel) begin
         if (req.prefix_last) begin
            entry_in    = entry_ff + COUNT_W'(1);
            load_pos_in = '0;
         end else begin
            load_pos_in = load_next;
         end
      end

      if (accept && req.command == CMD_CLEAR) begin
         total_in = '0;
         fmt_in   = '0;
         unk_in   = '0;
      end else if (finish) begin
         total_in = total_ff + 32'd1;
         if (status == ST_INVALID) begin
            fmt_in = fmt_ff + 32'd1;
         end else if (status == ST_UNKNOWN) begin
            unk_in = unk_ff + 32'd1;
         end
      end
   end

   assign res_valid          = finish;
   assign res.status         = status;
   assign res.entry_index    = (status == ST_MATCH) ? 4'(best_idx_ff) : 4'd0;
   assign res.match_length   = (status == ST_MATCH) ? 4'(best_len_ff) : 4'd0;
   assign res.total_count    = total_in;
   assign res.invalid_count  = fmt_in;
   assign res.unknown_count  = unk_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= 1'b0;
         started_ff  <= 1'b0;
         hash_ff     <= 1'b1;
         pending_ff  <= 1'b0;
         invalid_ff  <= 1'b0;
         pos_ff      <= '0;
         best_idx_ff <= '0;
         best_len_ff <= '0;
         entry_ff    <= '0;
         load_pos_ff <= '0;
         total_ff    <= '0;
         fmt_ff      <= '0;
         unk_ff      <= '0;
      end else begin
         nonempty_ff <= nonempty_in;
         started_ff  <= started_in;
         hash_ff     <= hash_in;
         pending_ff  <= pending_in;
         invalid_ff  <= invalid_in;
         pos_ff      <= pos_in;
         best_idx_ff <= best_idx_in;
         best_len_ff <= best_len_in;
         entry_ff    <= entry_in;
         load_pos_ff <= load_pos_in;
         total_ff    <= total_in;
         fmt_ff      <= fmt_in;
         unk_ff      <= unk_in;
      end
   end

endmodule

FILE: rtl/text_command_longest_prefix_matcher_top.sv
// Top level: line control, row of prefix cells and the two-deep result buffer.
//
//   channel  direction  payload   transfer when
//   req      in         req_type  req_valid && req_ready
//   rsp      out        rsp_type  rsp_valid && rsp_ready
//
// One item enters per cycle while req_ready is high; a line end's result is registered in the result
// or skid register before it shows on rsp. All cells compare the cleaned byte at once; the winner
// ripples along the cell row. A result register plus a skid register keep req_ready high while one
// result waits. req_ready drops only while both result registers hold data.
// Synchronous reset clears line state, entries and counters; no clearing pass.
module text_command_longest_prefix_matcher_top
   import tlpm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cell_ctrl_type ctrl;
   chain_type     chain_w [MAX_ENTRIES+1];
   logic          accept;
   logic          res_valid;
   rsp_type       res;

   logic          out_valid_ff,  out_valid_in;
   rsp_type       out_ff,        out_in;
   logic          skid_valid_ff, skid_valid_in;
   rsp_type       skid_ff,       skid_in;
   logic          pop;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign pop       = out_valid_ff && rsp_ready;

   assign chain_w[0] = '0;

   tlpm_line u_line (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .chain     (chain_w[MAX_ENTRIES]),
      .ctrl      (ctrl),
      .res_valid (res_valid),
      .res       (res)
   );

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      tlpm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .cell_index (ENTRY_W'(i)),
         .chain_in   (chain_w[i]),
         .chain_out  (chain_w[i+1])
      );
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
      if (res_valid) begin
         if (!out_valid_ff || pop) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: rtl/tlpm_checker.sv
// Port-level assertions for the command line prefix matcher, bound to the top level.
module tlpm_checker
   import tlpm_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transfer dropped or changed while stalled");

   a_ready_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("req_ready low with no result waiting");

   a_nomatch_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_MATCH |->
         rsp_data.entry_index == 4'd0 && rsp_data.match_length == 4'd0)
      else $error("entry or length set on a line that did not match");

   a_match_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_MATCH |->
         rsp_data.match_length != 4'd0 && rsp_data.match_length <= 4'(MAX_PREFIX_LEN))
      else $error("matched result with bad length");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("result pending after reset");

endmodule

bind text_command_longest_prefix_matcher_top tlpm_checker u_tlpm_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench: directed and random command lines checked against a line predictor.
module tb_top;
   import tlpm_pkg::*;

   localparam logic [1:0] CMD_UNUSED   = 2'd3;
   localparam int         HOLD_CYCLES  = 120;
   localparam int         TEXT_MAX     = MAX_PREFIX_LEN + 2;
   localparam int         DRAIN_CYCLES = 10;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   text_command_longest_prefix_matcher_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // line predictor state
   logic [7:0]             pfx_bytes [MAX_ENTRIES][MAX_PREFIX_LEN];
   int                     pfx_len [MAX_ENTRIES];
   int                     entries_used;
   int                     load_idx;
   bit                     line_seen;
   bit                     content_seen;
   bit                     hash_allowed;
   bit                     space_held;
   bit                     format_bad;
   int                     clean_len;
   logic [MAX_ENTRIES-1:0] live_entries;
   logic [31:0]            lines_total;
   logic [31:0]            lines_invalid;
   logic [31:0]            lines_unknown;
   rsp_type                expected_line_results [$];

   // stimulus side
   bit                     failed;
   bit                     idle_on;
   int                     hold_request;
   int                     counted_items;
   int                     stim_entries;
   int                     stim_pos;
   logic [7:0]             known_text [MAX_ENTRIES][TEXT_MAX];
   int                     known_len [MAX_ENTRIES];
   string                  line_chars = "ABC12:_.-";
   string                  bad_chars  = "!@#$~/";

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic void clear_line_tracking();
      line_seen    = 1'b0;
      content_seen = 1'b0;
      hash_allowed = 1'b1;
      space_held   = 1'b0;
      format_bad   = 1'b0;
      clean_len    = 0;
      live_entries = '1;
   endfunction

   function automatic void predict_line_result(req_type item);
      logic [7:0] ch;
      rsp_type    res;
      int         best_len;
      int         best_idx;
      ch = item.data_byte;
      case (item.command)
         CMD_BYTE: begin
            if (ch == CH_LF || ch == CH_CR) begin
               if (line_seen) begin
                  lines_total++;
                  best_len = 0;
                  best_idx = 0;
                  res      = '0;
                  if (format_bad || clean_len == 0) begin
                     lines_invalid++;
                     res.status = ST_INVALID;
                  end else begin
                     for (int i = 0; i < entries_used; i++) begin
                        if (live_entries[i] && pfx_len[i] <= clean_len &&
                            pfx_len[i] > best_len) begin
                           best_idx = i;
                           best_len = pfx_len[i];
                        end
                     end
                     if (best_len == 0) begin
                        lines_unknown++;
                        res.status = ST_UNKNOWN;
                     end else begin
                        res.status       = ST_MATCH;
                        res.entry_index  = 4'(best_idx);
                        res.match_length = 4'(best_len);
                     end
                  end
                  res.total_count   = lines_total;
                  res.invalid_count = lines_invalid;
                  res.unknown_count = lines_unknown;
                  expected_line_results.push_back(res);
                  clear_line_tracking();
               end
            end else if (ch >= CH_SPACE && ch <= CH_TILDE) begin
               line_seen = 1'b1;
               if (ch == CH_SPACE) begin
                  if (content_seen) space_held = 1'b1;
               end else begin
                  if (ch >= CH_LOW_A && ch <= CH_LOW_Z) ch = ch - CASE_DIFF;
                  if (space_held) begin
                     format_bad = 1'b1;
                     space_held = 1'b0;
                  end
                  content_seen = 1'b1;
                  if (hash_allowed && ch == CH_HASH) begin
                     hash_allowed = 1'b0;
                  end else begin
                     hash_allowed = 1'b0;
                     if (!((ch >= CH_ZERO && ch <= CH_NINE) || (ch >= CH_UP_A && ch <= CH_UP_Z) ||
                           ch == CH_COLON || ch == CH_UNDER || ch == CH_DOT || ch == CH_DASH))
                        format_bad = 1'b1;
                     if (clean_len < MAX_PREFIX_LEN) begin
                        for (int i = 0; i < entries_used; i++) begin
                           if (clean_len < pfx_len[i] && pfx_bytes[i][clean_len] != ch)
                              live_entries[i] = 1'b0;
                        end
                        clean_len++;
                     end
                  end
               end
            end
         end
         CMD_PREFIX: begin
            if (entries_used < MAX_ENTRIES) begin
               if (load_idx < MAX_PREFIX_LEN) begin
                  pfx_bytes[entries_used][load_idx] = item.data_byte;
                  load_idx++;
               end
               if (item.prefix_last) begin
                  pfx_len[entries_used] = load_idx;
                  if (clean_len > 0) live_entries[entries_used] = 1'b0;
                  entries_used++;
                  load_idx = 0;
               end
            end
         end
         CMD_CLEAR: begin
            lines_total   = '0;
            lines_invalid = '0;
            lines_unknown = '0;
         end
         default: ;
      endcase
   endfunction

   function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
      if (want_v !== got_v) begin
         failed = 1'b1;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      end
   endfunction

   always @(posedge clock) begin : result_monitor
      rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) predict_line_result(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_line_results.size() == 0) begin
               failed = 1'b1;
               $display("%0t: unexpected result, expected none, actual status %0d",
                        $time, rsp_data.status);
            end else begin
               want = expected_line_results.pop_front();
               check_field("status", 32'(want.status), 32'(rsp_data.status));
               check_field("entry_index", 32'(want.entry_index), 32'(rsp_data.entry_index));
               check_field("match_length", 32'(want.match_length),
                           32'(rsp_data.match_length));
               check_field("total_count", want.total_count, rsp_data.total_count);
               check_field("invalid_count", want.invalid_count, rsp_data.invalid_count);
               check_field("unknown_count", want.unknown_count, rsp_data.unknown_count);
            end
         end
      end
   end

   initial begin : result_receiver
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
         end else if (stall_left == 0 && idle_on && $urandom_range(0, 3) == 0) begin
            stall_left = $urandom_range(1, 3);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic [1:0] cmd, input logic [7:0] data, input logic is_last);
      req_type item;
      int      gap;
      item.command     = cmd;
      item.data_byte   = data;
      item.prefix_last = is_last;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (!(cmd == CMD_UNUSED || (cmd == CMD_PREFIX && stim_entries >= MAX_ENTRIES)))
         counted_items++;
   endtask

   task automatic send_text(input string text);
      for (int i = 0; i < text.len(); i++) send_item(CMD_BYTE, text[i], 1'b0);
   endtask

   task automatic register_prefix_byte(input logic [7:0] ch, input logic is_last);
      send_item(CMD_PREFIX, ch, is_last);
      if (stim_entries < MAX_ENTRIES) begin
         if (stim_pos < TEXT_MAX) begin
            known_text[stim_entries][stim_pos] = ch;
            stim_pos++;
         end
         if (is_last) begin
            known_len[stim_entries] = stim_pos;
            stim_entries++;
            stim_pos = 0;
         end
      end
   endtask

   task automatic register_prefix(input string text);
      for (int i = 0; i < text.len(); i++) register_prefix_byte(text[i], i == text.len() - 1);
   endtask

   task automatic register_random_prefix();
      int         n;
      logic [7:0] ch;
      n = $urandom_range(1, TEXT_MAX);
      for (int i = 0; i < n; i++) begin
         ch = line_chars[$urandom_range(0, line_chars.len() - 1)];
         if (ch >= CH_UP_A && ch <= CH_UP_Z && $urandom_range(0, 7) == 0) ch = ch + CASE_DIFF;
         register_prefix_byte(ch, i == n - 1);
      end
   endtask

   function automatic logic [7:0] vary_case(logic [7:0] ch);
      if (ch >= CH_UP_A && ch <= CH_UP_Z && $urandom_range(0, 2) == 0) return ch + CASE_DIFF;
      return ch;
   endfunction

   function automatic logic [7:0] random_line_char();
      return vary_case(line_chars[$urandom_range(0, line_chars.len() - 1)]);
   endfunction

   task automatic send_random_line();
      logic [7:0] line_q [$];
      int         flaw;
      int         k;
      flaw = $urandom_range(0, 9);
      repeat ($urandom_range(0, 2)) line_q.push_back(CH_SPACE);
      if ($urandom_range(0, 5) == 0) line_q.push_back(CH_HASH);
      if (flaw == 5) begin
         if ($urandom_range(0, 1)) line_q.push_back(CH_SPACE);
      end else begin
         if (stim_entries > 0 && $urandom_range(0, 3) != 0) begin
            k = $urandom_range(0, stim_entries - 1);
            for (int j = 0; j < known_len[k]; j++) line_q.push_back(vary_case(known_text[k][j]));
         end
         repeat ($urandom_range(0, 3)) line_q.push_back(random_line_char());
         case (flaw)
            6: begin
               line_q.push_back(CH_SPACE);
               line_q.push_back(random_line_char());
            end
            7: line_q.push_back(bad_chars[$urandom_range(0, bad_chars.len() - 1)]);
            8: line_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                     : 8'($urandom_range(127, 255)));
            9: repeat ($urandom_range(6, 10)) line_q.push_back(random_line_char());
            default: ;
         endcase
      end
      repeat ($urandom_range(0, 2)) line_q.push_back(CH_SPACE);
      foreach (line_q[i]) send_item(CMD_BYTE, line_q[i], 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 15) == 0) register_random_prefix();
      send_item(CMD_BYTE, $urandom_range(0, 1) ? CH_CR : CH_LF, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) send_item(CMD_BYTE, CH_LF, 1'b0);
   endtask

   task automatic test_dropped_bytes();
      send_item(CMD_BYTE, CH_LF, 1'b0);
      send_item(CMD_BYTE, CH_CR, 1'b1);
      send_item(CMD_BYTE, 8'h00, 1'b0);
      send_item(CMD_BYTE, 8'hFF, 1'b1);
      send_item(CMD_BYTE, 8'h7F, 1'b0);
      send_item(CMD_UNUSED, 8'hFF, 1'b1);
      send_text("  \r");
      send_text("#\n");
   endtask

   task automatic test_prefix_registration();
      register_prefix("AB");
      register_prefix("ABC");
      register_prefix("ab");
      register_prefix("LONGPFX89");
      register_prefix("AB");
   endtask

   task automatic test_line_matching();
      send_text("ABCD\n");
      send_text(" #abx \n");
      send_text("ab\n");
      send_text("LONGPFX8Z\n");
      send_text("ZZ\n");
      send_text("A B\n");
      send_text("# A\n");
      send_text("A!\n");
      send_text("##A\r\n");
   endtask

   task automatic test_statistics_clear();
      send_text("AB");
      send_item(CMD_CLEAR, 8'hFF, 1'b1);
      send_text("\n");
   endtask

   task automatic test_registration_mid_line();
      send_text("A");
      register_prefix("A");
      send_text("\n");
      send_text(" #");
      register_prefix("B1");
      send_text("B1\n");
   endtask

   task automatic test_backpressure();
      hold_request = HOLD_CYCLES;
      repeat (8) send_text("AB\n");
   endtask

   task automatic test_full_table();
      while (stim_entries < MAX_ENTRIES) register_random_prefix();
      register_prefix("ZQ");
      send_text("ZQ\n");
   endtask

   task automatic test_random_lines(input int item_goal);
      int stop_at;
      stop_at = counted_items + item_goal;
      while (counted_items < stop_at) begin
         case ($urandom_range(0, 15))
            0:       register_random_prefix();
            1:       send_item(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            2:       send_item(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            3:       send_item(CMD_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            default: send_random_line();
         endcase
      end
   endtask

   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      idle_on       = 1'b1;
      failed        = 1'b0;
      hold_request  = 0;
      counted_items = 0;
      stim_entries  = 0;
      stim_pos      = 0;
      entries_used  = 0;
      load_idx      = 0;
      lines_total   = '0;
      lines_invalid = '0;
      lines_unknown = '0;
      clear_line_tracking();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_dropped_bytes();
      test_prefix_registration();
      test_line_matching();
      test_statistics_clear();
      test_registration_mid_line();
      test_random_lines(450);
      test_backpressure();
      test_random_lines(350);
      test_full_table();
      idle_on = 1'b0;
      test_random_lines(200);

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_line_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!failed && expected_line_results.size() == 0) begin
         $display("PASS text_command_longest_prefix_matcher_top");
      end else begin
         $display("FAIL text_command_longest_prefix_matcher_top");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("FAIL text_command_longest_prefix_matcher_top");
      $finish;
   end

endmodule
